// ===== rtl/mtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] MAC_TEXT_LEN = 5'd17;
  localparam logic [PosW-1:0] POS_SAT      = 5'd18;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;

  localparam logic [3:0] NIB_TEN = 4'd10;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // one character held between the input register and the parse stage
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } char_beat_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_dec_t;

  function automatic hex_dec_t hex_decode(input logic [7:0] c);
    hex_dec_t   d;
    logic [7:0] diff;
    d.bad = 1'b0;
    d.nib = 4'd0;
    if (c >= CHAR_UA && c <= CHAR_UF) begin
      diff  = c - CHAR_UA;
      d.nib = diff[3:0] + NIB_TEN;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      diff  = c - CHAR_LA;
      d.nib = diff[3:0] + NIB_TEN;
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      diff  = c - CHAR_0;
      d.nib = diff[3:0];
    end else begin
      diff  = 8'd0;
      d.bad = 1'b1;
    end
    return d;
  endfunction

  // positions 2, 5, 8, 11, 14 hold the separators
  function automatic logic is_sep_pos(input logic [PosW-1:0] pos);
    logic r;
    case (pos) inside
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mac_text_parser.sv =====
// An accepted terminator passes the input register, then the result register.
// Throughput: one character per cycle; a terminator moves into the result
//   register as the previous result beat leaves, so only a NUL that arrives
//   while a result is stalled holds the input.
// Reset: synchronous active-low rst_n clears the position count, error flag,
//   nibble register and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module mac_text_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_char_code,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_mac_value,
  output logic             out_parse_status
);

  mtp_pkg::char_beat_t beat;
  logic                core_ready;

  mtp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .core_ready   (core_ready),
    .beat         (beat)
  );

  mtp_parse u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat             (beat),
    .core_ready       (core_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mac_value    (out_mac_value),
    .out_parse_status (out_parse_status)
  );

endmodule

`default_nettype wire

// ===== rtl/mtp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtp_in_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_char_code,
  output logic                     in_stall,
  input  wire logic                core_ready,
  output mtp_pkg::char_beat_t      beat
);

  logic       valid_r, valid_nxt;
  logic [7:0] code_r;

  assign in_stall  = valid_r && !core_ready;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      code_r <= in_char_code;
    end
  end

  assign beat.valid = valid_r;
  assign beat.code  = code_r;

endmodule

`default_nettype wire

// ===== rtl/mtp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtp_parse (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mtp_pkg::char_beat_t beat,
  output logic                     core_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [47:0]              out_mac_value,
  output logic                     out_parse_status
);

  logic [mtp_pkg::PosW-1:0] pos_r, pos_nxt;
  logic                     bad_r, bad_nxt;
  logic [47:0]              shift_r, shift_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [47:0]              mac_r;
  logic                     status_r;

  logic                     is_nul;
  logic                     fire;
  logic                     fail;
  mtp_pkg::hex_dec_t        dec;

  assign is_nul = (beat.code == mtp_pkg::CHAR_NUL);
  // only a terminator needs room in the result register
  assign core_ready = !(is_nul && out_valid_r && out_stall);
  assign fire       = beat.valid && core_ready;
  assign dec        = mtp_pkg::hex_decode(beat.code);
  assign fail       = bad_r || (pos_r != mtp_pkg::MAC_TEXT_LEN);

  always_comb begin
    pos_nxt   = pos_r;
    bad_nxt   = bad_r;
    shift_nxt = shift_r;
    if (fire) begin
      if (is_nul) begin
        pos_nxt   = '0;
        bad_nxt   = 1'b0;
        shift_nxt = '0;
      end else begin
        if (pos_r >= mtp_pkg::MAC_TEXT_LEN) begin
          bad_nxt = 1'b1;
        end else if (mtp_pkg::is_sep_pos(pos_r)) begin
          if (beat.code != mtp_pkg::CHAR_COLON) begin
            bad_nxt = 1'b1;
          end
        end else if (dec.bad) begin
          bad_nxt = 1'b1;
        end else begin
          shift_nxt = {shift_r[43:0], dec.nib};
        end
        if (pos_r < mtp_pkg::POS_SAT) begin
          pos_nxt = pos_r + 5'd1;
        end
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || (fire && is_nul);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      bad_r       <= 1'b0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      bad_r       <= bad_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_nul) begin
      mac_r    <= fail ? 48'd0 : shift_r;
      status_r <= fail ? mtp_pkg::STATUS_BAD : mtp_pkg::STATUS_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mac_value    = mac_r;
  assign out_parse_status = status_r;

endmodule

`default_nettype wire
